// ===== src/pal_pkg.sv =====
package pal_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 16;
  localparam int unsigned VALUE_WIDTH_DEF = 32;

  localparam int unsigned REQ_W = 2;
  localparam int unsigned POS_W = 5;
  localparam int unsigned END_W = 4;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W = 5;

  localparam logic [REQ_W-1:0] REQ_APPEND = 2'd0;
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;
  localparam logic [REQ_W-1:0] REQ_RANGE = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD = 2'd2;

  // Shift command broadcast to every cell of the list.
  typedef struct packed {
    logic shift_up;
    logic shift_down;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

endpackage

// ===== src/paired_array_list_insert_remove.sv =====
// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_ready    req_type, position, end_position, values
// out_      output     out_valid / out_ready  status, removed pair, entry_count, last_of_run
//
// Append, insert and every refused request are answered with a single result.
// A remove of n entries first checks the request, then returns one result per
// removed entry, as the cells from the removed position up shift down by one each time.
// A result waiting in the output register holds off the next item until it is taken.
// Synchronous active-low reset empties the list; a stalled output holds the
// row of cells in place.
module paired_array_list_insert_remove #(
  parameter int unsigned MAX_ENTRIES = pal_pkg::MAX_ENTRIES_DEF,
  parameter int unsigned VALUE_WIDTH = pal_pkg::VALUE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [pal_pkg::REQ_W-1:0]      in_req_type,
  input  logic [pal_pkg::POS_W-1:0]      in_position,
  input  logic [pal_pkg::END_W-1:0]      in_end_position,
  input  logic [pal_pkg::DATA_W-1:0]     in_first_value,
  input  logic [pal_pkg::DATA_W-1:0]     in_second_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [pal_pkg::STATUS_W-1:0]   out_status,
  output logic [pal_pkg::DATA_W-1:0]     out_removed_first,
  output logic [pal_pkg::DATA_W-1:0]     out_removed_second,
  output logic [pal_pkg::COUNT_W-1:0]    out_entry_count,
  output logic                           out_last_of_run
);

  localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CMPW = (CW > pal_pkg::POS_W) ? CW : pal_pkg::POS_W;

  pal_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [IW-1:0] cur_pos_r, cur_pos_nxt;
  logic [IW-1:0] rem_r, rem_nxt;

  logic out_valid_r, out_valid_nxt;
  logic [pal_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [pal_pkg::DATA_W-1:0] out_first_r, out_first_nxt;
  logic [pal_pkg::DATA_W-1:0] out_second_r, out_second_nxt;
  logic [pal_pkg::COUNT_W-1:0] out_count_r, out_count_nxt;
  logic out_last_r, out_last_nxt;

  logic slot_free;
  logic accept;
  logic drain_step;
  logic is_add;
  logic is_full;
  logic add_bad;
  logic add_ok;
  logic rm_bad;
  logic [CMPW-1:0] count_w;
  logic [CMPW-1:0] pos_w;
  logic [CMPW-1:0] ins_pos_w;
  logic [CMPW-1:0] end_w;

  pal_pkg::cell_ctrl_t cell_ctrl;
  logic [IW-1:0] cell_pos;
  logic [VALUE_WIDTH-1:0] new_first;
  logic [VALUE_WIDTH-1:0] new_second;
  logic [VALUE_WIDTH-1:0] cell_first [MAX_ENTRIES];
  logic [VALUE_WIDTH-1:0] cell_second [MAX_ENTRIES];
  logic [VALUE_WIDTH-1:0] low_first [MAX_ENTRIES];
  logic [VALUE_WIDTH-1:0] low_second [MAX_ENTRIES];
  logic [VALUE_WIDTH-1:0] up_first [MAX_ENTRIES];
  logic [VALUE_WIDTH-1:0] up_second [MAX_ENTRIES];

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == pal_pkg::ST_IDLE) && slot_free;
  assign accept = in_valid && in_ready;
  assign drain_step = (state_r == pal_pkg::ST_DRAIN) && slot_free;

  assign is_add = (in_req_type == pal_pkg::REQ_APPEND) || (in_req_type == pal_pkg::REQ_INSERT);
  assign count_w = CMPW'(count_r);
  assign pos_w = CMPW'(in_position);
  assign is_full = (count_r >= CW'(MAX_ENTRIES));
  assign ins_pos_w = (in_req_type == pal_pkg::REQ_APPEND) ? count_w : pos_w;
  assign add_bad = ins_pos_w > count_w;
  assign add_ok = is_add && !is_full && !add_bad;
  assign end_w = (in_req_type == pal_pkg::REQ_REMOVE) ? pos_w : CMPW'(in_end_position);
  assign rm_bad = (pos_w > end_w) || (end_w >= count_w);

  assign new_first = VALUE_WIDTH'(in_first_value);
  assign new_second = VALUE_WIDTH'(in_second_value);

  assign cell_ctrl.shift_up = accept && add_ok;
  assign cell_ctrl.shift_down = drain_step;
  assign cell_pos = (state_r == pal_pkg::ST_DRAIN) ? cur_pos_r : IW'(ins_pos_w);

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    if (g == 0) begin : g_low_edge
      assign low_first[g] = cell_first[g];
      assign low_second[g] = cell_second[g];
    end else begin : g_low
      assign low_first[g] = cell_first[g-1];
      assign low_second[g] = cell_second[g-1];
    end
    if (g == MAX_ENTRIES - 1) begin : g_up_edge
      assign up_first[g] = cell_first[g];
      assign up_second[g] = cell_second[g];
    end else begin : g_up
      assign up_first[g] = cell_first[g+1];
      assign up_second[g] = cell_second[g+1];
    end

    pal_cell #(
      .VALUE_WIDTH(VALUE_WIDTH),
      .IW(IW),
      .IDX(g)
    ) u_cell (
      .clk(clk),
      .ctrl(cell_ctrl),
      .pos(cell_pos),
      .new_first(new_first),
      .new_second(new_second),
      .lower_first(low_first[g]),
      .lower_second(low_second[g]),
      .upper_first(up_first[g]),
      .upper_second(up_second[g]),
      .first_q(cell_first[g]),
      .second_q(cell_second[g])
    );
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    cur_pos_nxt = cur_pos_r;
    rem_nxt = rem_r;
    out_valid_nxt = out_valid_r;
    out_status_nxt = out_status_r;
    out_first_nxt = out_first_r;
    out_second_nxt = out_second_r;
    out_count_nxt = out_count_r;
    out_last_nxt = out_last_r;

    if (slot_free) begin
      out_valid_nxt = 1'b0;
    end

    if (accept) begin
      out_first_nxt = '0;
      out_second_nxt = '0;
      out_last_nxt = 1'b1;
      out_count_nxt = pal_pkg::COUNT_W'(count_r);
      if (is_add) begin
        out_valid_nxt = 1'b1;
        if (is_full) begin
          out_status_nxt = pal_pkg::STATUS_FULL;
        end else if (add_bad) begin
          out_status_nxt = pal_pkg::STATUS_BAD;
        end else begin
          out_status_nxt = pal_pkg::STATUS_DONE;
          count_nxt = count_r + 1'b1;
          out_count_nxt = pal_pkg::COUNT_W'(count_nxt);
        end
      end else if (rm_bad) begin
        out_valid_nxt = 1'b1;
        out_status_nxt = pal_pkg::STATUS_BAD;
      end else begin
        state_nxt = pal_pkg::ST_DRAIN;
        cur_pos_nxt = IW'(pos_w);
        rem_nxt = IW'(end_w - pos_w);
      end
    end else if (drain_step) begin
      out_valid_nxt = 1'b1;
      out_status_nxt = pal_pkg::STATUS_DONE;
      out_first_nxt = pal_pkg::DATA_W'(cell_first[cur_pos_r]);
      out_second_nxt = pal_pkg::DATA_W'(cell_second[cur_pos_r]);
      count_nxt = count_r - 1'b1;
      out_count_nxt = pal_pkg::COUNT_W'(count_nxt);
      out_last_nxt = (rem_r == '0);
      if (rem_r == '0) begin
        state_nxt = pal_pkg::ST_IDLE;
      end else begin
        rem_nxt = rem_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pal_pkg::ST_IDLE;
      count_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_pos_r <= cur_pos_nxt;
    rem_r <= rem_nxt;
    out_status_r <= out_status_nxt;
    out_first_r <= out_first_nxt;
    out_second_r <= out_second_nxt;
    out_count_r <= out_count_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_status = out_status_r;
  assign out_removed_first = out_first_r;
  assign out_removed_second = out_second_r;
  assign out_entry_count = out_count_r;
  assign out_last_of_run = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_ENTRIES))
    else $error("Entry count exceeds the list capacity.");

  a_drain_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pal_pkg::ST_DRAIN) |->
      (CMPW'(cur_pos_r) + CMPW'(rem_r) < CMPW'(count_r)))
    else $error("Range removal reaches past the stored entries.");

  a_partial_only_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> (state_r == pal_pkg::ST_DRAIN))
    else $error("A non-final result exists outside a range removal.");

  a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && add_ok) |=> (count_r == $past(count_r) + 1'b1))
    else $error("Accepted append or insert did not grow the list.");

endmodule

// ===== src/pal_cell.sv =====
module pal_cell #(
  parameter int unsigned VALUE_WIDTH = pal_pkg::VALUE_WIDTH_DEF,
  parameter int unsigned IW = 4,
  parameter int unsigned IDX = 0
) (
  input  logic                   clk,
  input  pal_pkg::cell_ctrl_t    ctrl,
  input  logic [IW-1:0]          pos,
  input  logic [VALUE_WIDTH-1:0] new_first,
  input  logic [VALUE_WIDTH-1:0] new_second,
  input  logic [VALUE_WIDTH-1:0] lower_first,
  input  logic [VALUE_WIDTH-1:0] lower_second,
  input  logic [VALUE_WIDTH-1:0] upper_first,
  input  logic [VALUE_WIDTH-1:0] upper_second,
  output logic [VALUE_WIDTH-1:0] first_q,
  output logic [VALUE_WIDTH-1:0] second_q
);

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic [VALUE_WIDTH-1:0] first_r, first_nxt;
  logic [VALUE_WIDTH-1:0] second_r, second_nxt;

  always_comb begin
    first_nxt = first_r;
    second_nxt = second_r;
    if (ctrl.shift_up) begin
      if (MY_IDX > pos) begin
        first_nxt = lower_first;
        second_nxt = lower_second;
      end else if (MY_IDX == pos) begin
        first_nxt = new_first;
        second_nxt = new_second;
      end
    end else if (ctrl.shift_down) begin
      if (MY_IDX >= pos) begin
        first_nxt = upper_first;
        second_nxt = upper_second;
      end
    end
  end

  always_ff @(posedge clk) begin
    first_r <= first_nxt;
    second_r <= second_nxt;
  end

  assign first_q = first_r;
  assign second_q = second_r;

endmodule
